[sv/swm_pkg.sv]
// Shared constants and types for the sliding-window median filter.
// No dependencies; every other file of the block depends on this package.
package swm_pkg;

	// Width of one latency sample and of the median result.
	localparam int SAMPLE_W = 32;
	// Width of the window size register and of the held count field.
	localparam int WIN_W = 6;
	// Default capacity of the cell chain.
	localparam int MAX_WINDOW_DEF = 32;
	// Window size after reset.
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);

	// Movement flags that one cell shows its two neighbors.
	typedef struct packed {
		logic mv_left;   // this cell's word moves one place toward cell 0
		logic mv_right;  // this cell's word moves one place away from cell 0
		logic del;       // this cell holds the oldest word and drops it
	} swm_move_t;

endpackage

[sv/swm_if.sv]
// Valid/ready channel interfaces for the sliding-window median filter.
// Depends on swm_pkg for the field widths.

// Sample channel: one latency word per handshake.
interface swm_sample_if;
	logic                         valid;
	logic                         ready;
	logic [swm_pkg::SAMPLE_W-1:0] latency_us;

	modport source (output valid, output latency_us, input ready);
	modport sink (input valid, input latency_us, output ready);
endinterface

// Result channel: median and held count per handshake.
interface swm_result_if;
	logic                         valid;
	logic                         ready;
	logic [swm_pkg::SAMPLE_W-1:0] median_us;
	logic [swm_pkg::WIN_W-1:0]    held_count;

	modport source (output valid, output median_us, output held_count, input ready);
	modport sink (input valid, input median_us, input held_count, output ready);
endinterface

// Configuration channel: carries the window size register.
interface swm_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [swm_pkg::WIN_W-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

[sv/sliding_window_median.sv]
// Top level of the sliding-window median filter: sorted cell chain and control.
// Depends on swm_pkg, swm_if, swm_cell and swm_median.
//
//   channel  | dir | word                        | handshake
//   ---------+-----+-----------------------------+-------------
//   samples  | in  | latency_us                  | valid/ready
//   results  | out | median_us, held_count       | valid/ready
//   cfg      | in  | window_size (clears window) | valid/ready
//
// One sample per cycle unless results stall; results pass s2, then the result register.
// The cell chain inserts the new word and drops the oldest in the same cycle.
// A stalled result register stalls the whole pipeline and the sample side.
// Reset empties the window and sets the window size to 32; cfg is always ready.
module sliding_window_median #(
	parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
	input logic          clk,
	input logic          arst_n,
	swm_cfg_if.sink      cfg,
	swm_sample_if.sink   samples,
	swm_result_if.source results
);
	import swm_pkg::*;

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [WIN_W-1:0]    window_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       eff_w;
	logic [AW-1:0]       top_age;
	logic                evict;
	logic                adv;
	logic                in_acc;
	logic                cfg_acc;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] v_old;
	logic [SAMPLE_W-1:0] vals [MAX_WINDOW];
	logic [AW-1:0]       ages [MAX_WINDOW];
	swm_move_t           mvs [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] del_vec;

	assign cfg.ready     = 1'b1;
	assign cfg_acc       = cfg.valid;
	assign samples.ready = adv;
	assign in_acc        = samples.valid && adv;

	// Effective window: zero counts as one, large sizes saturate.
	always_comb begin
		if (window_q == '0) begin
			eff_w = CW'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			eff_w = CW'(MAX_WINDOW);
		end else begin
			eff_w = CW'(window_q);
		end
		top_age = AW'(eff_w - 1'b1);
		evict   = count_q == eff_w;
	end

	// Window size, fill count and first pipeline valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_acc) begin
				window_q <= cfg.window_size;
				count_q  <= '0;
			end else if (in_acc && !evict) begin
				count_q <= count_q + 1'b1;
			end
			if (adv) begin
				valid_s1 <= samples.valid;
			end
		end
	end

	// The oldest word is broadcast so each cell knows if it lies past it.
	always_comb begin
		v_old = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			del_vec[i] = mvs[i].del;
			v_old      = v_old | (mvs[i].del ? vals[i] : '0);
		end
	end

	// The sorted chain of cells, each wired to its two neighbors.
	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		logic [SAMPLE_W-1:0] lv;
		logic [SAMPLE_W-1:0] rv;
		logic [AW-1:0]       la;
		logic [AW-1:0]       ra;
		swm_move_t           lm;
		swm_move_t           rm;

		if (g == 0) begin : g_lo
			assign lv = '0;
			assign la = '0;
			assign lm = '0;
		end else begin : g_lo
			assign lv = vals[g-1];
			assign la = ages[g-1];
			assign lm = mvs[g-1];
		end

		if (g == MAX_WINDOW - 1) begin : g_hi
			assign rv = '0;
			assign ra = '0;
			assign rm = '0;
		end else begin : g_hi
			assign rv = vals[g+1];
			assign ra = ages[g+1];
			assign rm = mvs[g+1];
		end

		swm_cell #(
			.IDX (g),
			.CW  (CW),
			.AW  (AW)
		) u_cell (
			.clk       (clk),
			.en        (in_acc),
			.x         (samples.latency_us),
			.v_old     (v_old),
			.evict     (evict),
			.count     (count_q),
			.top_age   (top_age),
			.left_val  (lv),
			.left_age  (la),
			.left_mv   (lm),
			.right_val (rv),
			.right_age (ra),
			.right_mv  (rm),
			.val       (vals[g]),
			.age       (ages[g]),
			.mv        (mvs[g])
		);
	end

	// Middle selection, averaging and the result register.
	swm_median #(
		.MAX_WINDOW (MAX_WINDOW),
		.CW         (CW),
		.AW         (AW)
	) u_median (
		.clk        (clk),
		.arst_n     (arst_n),
		.ready      (results.ready),
		.valid_s1   (valid_s1),
		.vals       (vals),
		.count      (count_q),
		.adv        (adv),
		.out_valid  (results.valid),
		.median_us  (results.median_us),
		.held_count (results.held_count)
	);

`ifndef SYNTHESIS
	// A sample into a window that is not full, with no size write, grows the count by one.
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !evict && !cfg_acc |=> count_q == $past(count_q) + 1'b1)
		else $error("fill count did not grow");

	// When the window is full exactly one cell drops its word.
	a_one_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && evict |-> $onehot(del_vec))
		else $error("full window must drop exactly one word");

	// A window size write empties the window.
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> count_q == '0)
		else $error("window not emptied by size write");
`endif

endmodule

[sv/swm_cell.sv]
// One cell of the sorted sample chain: holds a sample word and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median.
module swm_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6,
	parameter int AW  = 5
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [swm_pkg::SAMPLE_W-1:0] x,
	input  logic [swm_pkg::SAMPLE_W-1:0] v_old,
	input  logic                         evict,
	input  logic [CW-1:0]                count,
	input  logic [AW-1:0]                top_age,
	input  logic [swm_pkg::SAMPLE_W-1:0] left_val,
	input  logic [AW-1:0]                left_age,
	input  swm_pkg::swm_move_t           left_mv,
	input  logic [swm_pkg::SAMPLE_W-1:0] right_val,
	input  logic [AW-1:0]                right_age,
	input  swm_pkg::swm_move_t           right_mv,
	output logic [swm_pkg::SAMPLE_W-1:0] val,
	output logic [AW-1:0]                age,
	output swm_pkg::swm_move_t           mv
);
	import swm_pkg::*;

	logic [SAMPLE_W-1:0] val_q;
	logic [AW-1:0]       age_q;
	logic                valid;
	logic                rem;
	logic                ad;
	logic                ge;
	logic                stay;

	// The chain is sorted by value, ties ordered youngest first.
	// A cell past the dropped word slides left; a cell at or above the new
	// word slides right; doing both leaves it in place.
	always_comb begin
		valid       = int'(count) > IDX;
		mv.del      = evict && valid && (age_q == top_age);
		rem         = valid && !mv.del;
		ad          = evict && (val_q > v_old);
		ge          = val_q >= x;
		mv.mv_left  = rem && ad && !ge;
		mv.mv_right = rem && !ad && ge;
		stay        = rem && (ad == ge);
	end

	// Take a neighbor's word, keep our own, or else take the new sample.
	always_ff @(posedge clk) begin
		if (en) begin
			if (right_mv.mv_left) begin
				val_q <= right_val;
				age_q <= right_age + 1'b1;
			end else if (left_mv.mv_right) begin
				val_q <= left_val;
				age_q <= left_age + 1'b1;
			end else if (stay) begin
				age_q <= age_q + 1'b1;
			end else begin
				val_q <= x;
				age_q <= '0;
			end
		end
	end

	assign val = val_q;
	assign age = age_q;

endmodule

[sv/swm_median.sv]
// Output stages: picks the middle cells, averages them, holds the result word.
// Depends on swm_pkg; fed by the cell chain in sliding_window_median.
module swm_median #(
	parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
	parameter int CW         = 6,
	parameter int AW         = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ready,
	input  logic                         valid_s1,
	input  logic [swm_pkg::SAMPLE_W-1:0] vals [MAX_WINDOW],
	input  logic [CW-1:0]                count,
	output logic                         adv,
	output logic                         out_valid,
	output logic [swm_pkg::SAMPLE_W-1:0] median_us,
	output logic [swm_pkg::WIN_W-1:0]    held_count
);
	import swm_pkg::*;

	logic [AW-1:0]       hi_idx;
	logic [AW-1:0]       lo_idx;
	logic                valid_s2;
	logic [SAMPLE_W-1:0] lo_s2;
	logic [SAMPLE_W-1:0] hi_s2;
	logic [WIN_W-1:0]    held_s2;
	logic [SAMPLE_W:0]   sum;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] median_q;
	logic [WIN_W-1:0]    held_q;

	// The whole pipeline advances whenever the result register is free.
	assign adv = !out_valid_q || ready;

	// Middle positions: one cell for an odd count, two for an even count.
	always_comb begin
		hi_idx = AW'(count >> 1);
		lo_idx = count[0] ? hi_idx : hi_idx - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Middle words are captured, then averaged at full width.
	assign sum = {1'b0, lo_s2} + {1'b0, hi_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s2    <= vals[lo_idx];
			hi_s2    <= vals[hi_idx];
			held_s2  <= WIN_W'(count);
			median_q <= sum[SAMPLE_W:1];
			held_q   <= held_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign median_us  = median_q;
	assign held_count = held_q;

endmodule
